FILE: design/ttcw_pkg.sv
package ttcw_pkg;

  // Default geometry
  localparam int unsigned DefColumns = 80;
  localparam int unsigned DefRows    = 25;

  // Queue depths between the parts
  localparam int unsigned CmdDepth = 2;
  localparam int unsigned ResDepth = 2;

  // Fixed field widths
  localparam int unsigned OpW    = 2;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned RowFW  = 5;
  localparam int unsigned ColFW  = 7;
  localparam int unsigned CellW  = 16;

  localparam logic [ByteW-1:0] NewlineChar = 8'd10;
  localparam logic [ByteW-1:0] SpaceChar   = 8'd32;
  localparam logic [ByteW-1:0] ResetAttr   = 8'h07;
  localparam logic [CellW-1:0] ResetCell   = {ResetAttr, SpaceChar};

  typedef enum logic [OpW-1:0] {
    OP_PUT   = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } opcode_e;

  typedef enum logic [2:0] {
    CMD_PUT,
    CMD_NEWLINE,
    CMD_READ,
    CMD_CLEAR,
    CMD_NOP
  } cmd_kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_COPY,
    ST_FILL
  } back_state_e;

  typedef struct packed {
    logic [OpW-1:0]   opcode;
    logic [ByteW-1:0] char_code;
    logic [ByteW-1:0] attribute;
    logic [RowFW-1:0] read_row;
    logic [ColFW-1:0] read_col;
  } ttcw_item_t;

  typedef struct packed {
    logic [CellW-1:0] cell_value;
    logic [RowFW-1:0] row_now;
    logic [ColFW-1:0] col_now;
    logic             scrolled;
  } ttcw_result_t;

  typedef struct packed {
    cmd_kind_e        kind;
    logic [ByteW-1:0] char_code;
    logic [ByteW-1:0] attribute;
    logic [RowFW-1:0] row;
    logic [ColFW-1:0] col;
  } ttcw_cmd_t;

  // Handshake between the back end and the two queues around it
  typedef struct packed {
    logic cmd_empty;
    logic res_full;
  } back_status_t;

  typedef struct packed {
    logic cmd_pop;
    logic res_push;
  } back_ctrl_t;

endpackage

FILE: design/ttcw_fifo.sv
module ttcw_fifo import ttcw_pkg::*; #(
  parameter type         T     = logic,
  parameter int unsigned DEPTH = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     data_i,
  output logic full_o,
  input  logic pop_i,
  output T     data_o,
  output logic empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NW = $clog2(DEPTH + 1);

  T                mem_q [DEPTH];
  logic [PW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [NW-1:0]   cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == NW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

FILE: design/ttcw_front.sv
module ttcw_front import ttcw_pkg::*; #(
  parameter int unsigned COLUMNS = DefColumns,
  parameter int unsigned ROWS    = DefRows
) (
  input  ttcw_item_t item_i,
  input  logic       push,
  output logic       full,
  input  logic       cmd_full_i,
  output logic       cmd_push_o,
  output ttcw_cmd_t  cmd_o
);

  logic in_range;

  assign full       = cmd_full_i;
  assign cmd_push_o = push;
  assign in_range   = (int'(item_i.read_row) < ROWS) && (int'(item_i.read_col) < COLUMNS);

  always_comb begin
    cmd_o.char_code = item_i.char_code;
    cmd_o.attribute = item_i.attribute;
    cmd_o.row       = item_i.read_row;
    cmd_o.col       = item_i.read_col;
    case (item_i.opcode)
      OP_PUT: begin
        cmd_o.kind = (item_i.char_code == NewlineChar) ? CMD_NEWLINE : CMD_PUT;
      end
      OP_READ: begin
        // out-of-range reads return zero and touch nothing
        cmd_o.kind = in_range ? CMD_READ : CMD_NOP;
      end
      OP_CLEAR: begin
        cmd_o.kind = CMD_CLEAR;
      end
      default: begin
        cmd_o.kind = CMD_NOP;
      end
    endcase
  end

endmodule

FILE: design/ttcw_back.sv
module ttcw_back import ttcw_pkg::*; #(
  parameter int unsigned COLUMNS = DefColumns,
  parameter int unsigned ROWS    = DefRows
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  back_status_t stat_i,
  output back_ctrl_t   ctrl_o,
  input  ttcw_cmd_t    cmd_i,
  output ttcw_result_t res_o
);

  localparam int unsigned Cells = ROWS * COLUMNS;
  localparam int unsigned AW    = $clog2(Cells);
  localparam int unsigned RW    = $clog2(ROWS);
  localparam int unsigned CW    = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam logic [AW-1:0] LastRowBase = AW'((ROWS - 1) * COLUMNS);
  localparam logic [AW-1:0] LastCell    = AW'(Cells - 1);

  logic [CellW-1:0] mem [Cells];
  logic [CellW-1:0] rdata_q;

  back_state_e      state_q, state_d;
  logic [RW-1:0]    row_q, row_d;
  logic [CW-1:0]    col_q, col_d;
  logic [AW-1:0]    k_q, k_d;
  logic [CellW-1:0] blank_q, blank_d;
  logic             pend_q, pend_d;
  logic             scroll_q, scroll_d;

  logic             we, re;
  logic [AW-1:0]    waddr, raddr, lin_addr;
  logic [CellW-1:0] wdata;
  logic [RW-1:0]    sel_row;
  logic [CW-1:0]    sel_col;
  logic             go;

  // one shared row*COLUMNS+col for cursor writes and cell reads
  always_comb begin
    if (cmd_i.kind == CMD_READ) begin
      sel_row = RW'(cmd_i.row);
      sel_col = CW'(cmd_i.col);
    end else begin
      sel_row = row_q;
      sel_col = col_q;
    end
    lin_addr = AW'(int'(sel_row) * COLUMNS + int'(sel_col));
  end

  assign go = (state_q == ST_IDLE) && !stat_i.cmd_empty && !stat_i.res_full;

  always_comb begin
    state_d         = state_q;
    row_d           = row_q;
    col_d           = col_q;
    k_d             = k_q;
    blank_d         = blank_q;
    pend_d          = pend_q;
    scroll_d        = scroll_q;
    we              = 1'b0;
    re              = 1'b0;
    waddr           = lin_addr;
    raddr           = lin_addr;
    wdata           = {cmd_i.attribute, cmd_i.char_code};
    ctrl_o.cmd_pop  = go;
    ctrl_o.res_push = 1'b0;
    res_o.cell_value = '0;
    res_o.scrolled   = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (go) begin
          case (cmd_i.kind)
            CMD_PUT: begin
              we = 1'b1;
              if (col_q == CW'(COLUMNS - 1)) begin
                col_d = '0;
                row_d = (row_q == RW'(ROWS - 1)) ? '0 : row_q + 1'b1;
              end else begin
                col_d = col_q + 1'b1;
              end
              ctrl_o.res_push = 1'b1;
            end
            CMD_NEWLINE: begin
              col_d = '0;
              if (row_q == RW'(ROWS - 1)) begin
                k_d      = '0;
                blank_d  = {cmd_i.attribute, SpaceChar};
                scroll_d = 1'b1;
                pend_d   = 1'b1;
                state_d  = ST_COPY;
              end else begin
                row_d           = row_q + 1'b1;
                ctrl_o.res_push = 1'b1;
              end
            end
            CMD_READ: begin
              re      = 1'b1;
              state_d = ST_READ;
            end
            CMD_CLEAR: begin
              row_d    = '0;
              col_d    = '0;
              k_d      = '0;
              blank_d  = ResetCell;
              scroll_d = 1'b0;
              pend_d   = 1'b1;
              state_d  = ST_FILL;
            end
            default: begin
              ctrl_o.res_push = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        res_o.cell_value = rdata_q;
        ctrl_o.res_push  = 1'b1;
        state_d          = ST_IDLE;
      end
      ST_COPY: begin
        // read k+COLUMNS, write the previous read into k-1
        raddr = k_q + AW'(COLUMNS);
        waddr = k_q - 1'b1;
        wdata = rdata_q;
        re    = (k_q != LastRowBase);
        we    = (k_q != '0);
        if (k_q == LastRowBase) begin
          state_d = ST_FILL;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      ST_FILL: begin
        we    = 1'b1;
        waddr = k_q;
        wdata = blank_q;
        if (k_q == LastCell) begin
          state_d          = ST_IDLE;
          pend_d           = 1'b0;
          ctrl_o.res_push  = pend_q;
          res_o.scrolled   = scroll_q;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    res_o.row_now = RowFW'(row_d);
    res_o.col_now = ColFW'(col_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_FILL;
      row_q    <= '0;
      col_q    <= '0;
      k_q      <= '0;
      blank_q  <= ResetCell;
      pend_q   <= 1'b0;
      scroll_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      row_q    <= row_d;
      col_q    <= col_d;
      k_q      <= k_d;
      blank_q  <= blank_d;
      pend_q   <= pend_d;
      scroll_q <= scroll_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

endmodule

FILE: design/text_terminal_char_writer.sv
// Channel  | Ports                       | Transaction when
// ---------+-----------------------------+---------------------------------
// item in  | push, full, item_i          | push && !full at rising clk_i
// result   | empty, pop, result_o        | pop && !empty at rising clk_i
//
// Back-end steps per item: put, newline without scroll, read out of range and
// unused opcode finish in the idle state; an in-range read also passes the
// read state (registered store read). A clear walks the ROWS*COLUMNS store
// one cell a cycle; a scroll copies (ROWS-1)*COLUMNS cells up one row, then
// blanks COLUMNS cells. After reset a clearing pass over all ROWS*COLUMNS cells
// fills the store with blanks; items are queued meanwhile but none completes.
// The command queue lets the front take items while the back end is busy;
// the result queue holds finished results while pop is low.
module text_terminal_char_writer import ttcw_pkg::*; #(
  parameter int unsigned COLUMNS = DefColumns,
  parameter int unsigned ROWS    = DefRows
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push,
  output logic         full,
  input  ttcw_item_t   item_i,
  output logic         empty,
  input  logic         pop,
  output ttcw_result_t result_o
);

  ttcw_cmd_t    front_cmd, back_cmd;
  logic         cmd_push, cmd_full;
  back_status_t back_stat;
  back_ctrl_t   back_ctrl;
  ttcw_result_t back_res;

  // Front end: decode opcode, spot newline, range-check reads
  ttcw_front #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_front (
    .item_i    (item_i),
    .push      (push),
    .full      (full),
    .cmd_full_i(cmd_full),
    .cmd_push_o(cmd_push),
    .cmd_o     (front_cmd)
  );

  // Short command queue between front and back
  ttcw_fifo #(
    .T    (ttcw_cmd_t),
    .DEPTH(CmdDepth)
  ) u_cmd_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .data_i (front_cmd),
    .full_o (cmd_full),
    .pop_i  (back_ctrl.cmd_pop),
    .data_o (back_cmd),
    .empty_o(back_stat.cmd_empty)
  );

  // Back end: cursor, screen store, scroll/clear sweeps
  ttcw_back #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_back (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .stat_i(back_stat),
    .ctrl_o(back_ctrl),
    .cmd_i (back_cmd),
    .res_o (back_res)
  );

  // Result queue; back end only takes a command when a slot is free
  ttcw_fifo #(
    .T    (ttcw_result_t),
    .DEPTH(ResDepth)
  ) u_res_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (back_ctrl.res_push),
    .data_i (back_res),
    .full_o (back_stat.res_full),
    .pop_i  (pop),
    .data_o (result_o),
    .empty_o(empty)
  );

endmodule

FILE: design/ttcw_checker.sv
module ttcw_assertions import ttcw_pkg::*; #(
  parameter int unsigned COLUMNS = DefColumns,
  parameter int unsigned ROWS    = DefRows
) (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         empty,
  input logic         pop,
  input ttcw_result_t result_o
);

  // Reported cursor is always on screen
  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (int'(result_o.row_now) < ROWS) && (int'(result_o.col_now) < COLUMNS))
    else $error("cursor off screen");

  // A scroll leaves the cursor at the start of the bottom row
  a_scroll_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && result_o.scrolled |->
      (result_o.row_now == RowFW'(ROWS - 1)) && (result_o.col_now == '0))
    else $error("scroll cursor wrong");

  // Only reads return a cell, and a scrolling put is no read
  a_scroll_cell: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && result_o.scrolled |-> result_o.cell_value == '0)
    else $error("scroll with cell value");

  // Waiting result holds until popped
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(result_o))
    else $error("result changed while waiting");

endmodule

bind text_terminal_char_writer ttcw_assertions #(
  .COLUMNS(COLUMNS),
  .ROWS   (ROWS)
) u_ttcw_assertions (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .empty   (empty),
  .pop     (pop),
  .result_o(result_o)
);

FILE: tb/sv/ttcw_checker.sv
// Watches both queue-style channels of the terminal writer, keeps its own copy
// of the screen and cursor, and compares every popped result with the oldest
// prediction.
module ttcw_checker import ttcw_pkg::*; #(
  parameter int unsigned COLUMNS = DefColumns,
  parameter int unsigned ROWS    = DefRows
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push,
  input  logic         full,
  input  ttcw_item_t   item_i,
  input  logic         empty,
  input  logic         pop,
  input  ttcw_result_t result_i,
  output int unsigned  fail_count_o,
  output int unsigned  outstanding_o,
  output int unsigned  scroll_count_o
);

  localparam int unsigned Cells = ROWS * COLUMNS;

  logic [CellW-1:0] screen [Cells];
  logic [RowFW-1:0] cur_row;
  logic [ColFW-1:0] cur_col;
  ttcw_result_t     predicted_results [$];
  int unsigned      mismatches;
  int unsigned      scrolls;

  task automatic blank_screen();
    for (int unsigned i = 0; i < Cells; i++) screen[i] = ResetCell;
  endtask

  // Applies one transaction to the shadow screen and returns its result.
  task automatic terminal_step(input ttcw_item_t it, output ttcw_result_t res);
    int unsigned idx;
    res = '0;
    case (it.opcode)
      OP_PUT: begin
        if (it.char_code == NewlineChar) begin
          cur_col = '0;
          if (int'(cur_row) + 1 >= int'(ROWS)) begin
            for (idx = 0; idx + COLUMNS < Cells; idx++) screen[idx] = screen[idx + COLUMNS];
            for (idx = (ROWS - 1) * COLUMNS; idx < Cells; idx++) begin
              screen[idx] = {it.attribute, SpaceChar};
            end
            cur_row = RowFW'(ROWS - 1);
            res.scrolled = 1'b1;
            scrolls++;
          end else begin
            cur_row++;
          end
        end else begin
          idx = cur_row * COLUMNS + cur_col;
          screen[idx] = {it.attribute, it.char_code};
          if (int'(cur_col) + 1 >= int'(COLUMNS)) begin
            cur_col = '0;
            // wraps to the top, no scroll
            if (int'(cur_row) + 1 >= int'(ROWS)) cur_row = '0;
            else cur_row++;
          end else begin
            cur_col++;
          end
        end
      end
      OP_READ: begin
        if (it.read_row < ROWS && it.read_col < COLUMNS) begin
          res.cell_value = screen[it.read_row * COLUMNS + it.read_col];
        end
      end
      OP_CLEAR: begin
        blank_screen();
        cur_row = '0;
        cur_col = '0;
      end
      default: ;
    endcase
    res.row_now = cur_row;
    res.col_now = cur_col;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    ttcw_result_t want;
    if (!rst_ni) begin
      blank_screen();
      cur_row = '0;
      cur_col = '0;
      predicted_results.delete();
      mismatches = 0;
      scrolls = 0;
    end else begin
      if (pop && !empty) begin
        if (predicted_results.size() == 0) begin
          $error("result popped with no transaction pending: %h", result_i);
          mismatches++;
        end else begin
          want = predicted_results.pop_front();
          if (result_i.cell_value !== want.cell_value) begin
            $error("cell_value: expected %h, actual %h", want.cell_value, result_i.cell_value);
            mismatches++;
          end
          if (result_i.row_now !== want.row_now) begin
            $error("row_now: expected %0d, actual %0d", want.row_now, result_i.row_now);
            mismatches++;
          end
          if (result_i.col_now !== want.col_now) begin
            $error("col_now: expected %0d, actual %0d", want.col_now, result_i.col_now);
            mismatches++;
          end
          if (result_i.scrolled !== want.scrolled) begin
            $error("scrolled: expected %b, actual %b", want.scrolled, result_i.scrolled);
            mismatches++;
          end
        end
      end
      if (push && !full) begin
        terminal_step(item_i, want);
        predicted_results.push_back(want);
      end
    end
    fail_count_o   <= mismatches;
    outstanding_o  <= predicted_results.size();
    scroll_count_o <= scrolls;
  end

endmodule

FILE: tb/sv/tb_top.sv
// Top of the terminal writer testbench: clock, reset, stimulus and verdict.
// Checking lives in ttcw_checker, which sits beside the block, and in the bound ttcw_assertions.
module tb_top;
  import ttcw_pkg::*;

  localparam int unsigned Cols        = DefColumns;
  localparam int unsigned Rows        = DefRows;
  localparam int unsigned ItemBits    = $bits(ttcw_item_t);
  // Opcode the block must treat as a no-op.
  localparam logic [OpW-1:0] OpUnused = 2'd3;
  // Directed part plus roughly 1900 random transactions.
  localparam int unsigned ItemTarget  = 1920;
  // Newlines and clears may each cost a full pass over the store, so the stimulus
  // caps how many it issues; this also bounds the run time.
  localparam int unsigned SlowCap     = 160;
  localparam int unsigned MaxGap      = 16;
  localparam int unsigned DrainCycles = 64;

  logic         clk_i  = 1'b0;
  logic         rst_ni = 1'b0;
  logic         push   = 1'b0;
  logic         pop    = 1'b0;
  logic         full;
  logic         empty;
  ttcw_item_t   item_i = '0;
  ttcw_result_t result_o;

  int unsigned fail_count;
  int unsigned outstanding;
  int unsigned scroll_count;

  // Stimulus bookkeeping, used for the budget and the summary.
  int unsigned n_items   = 0;
  int unsigned n_chars   = 0;
  int unsigned n_newline = 0;
  int unsigned n_reads   = 0;
  int unsigned n_clears  = 0;
  int unsigned n_unused  = 0;
  int unsigned slow_used = 0;
  // When set, that side runs back to back with no idle cycles.
  bit          send_calm = 1'b0;
  bit          pop_calm  = 1'b0;

  always #6 clk_i = ~clk_i;

  text_terminal_char_writer #(
    .COLUMNS(Cols),
    .ROWS   (Rows)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push    (push),
    .full    (full),
    .item_i  (item_i),
    .empty   (empty),
    .pop     (pop),
    .result_o(result_o)
  );

  ttcw_checker #(
    .COLUMNS(Cols),
    .ROWS   (Rows)
  ) u_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .item_i        (item_i),
    .empty         (empty),
    .pop           (pop),
    .result_i      (result_o),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding),
    .scroll_count_o(scroll_count)
  );

  // ---------------------------------------------------------------------------
  // Item builders. Fields an opcode ignores are left random so every input bit
  // toggles without changing what is being tested.
  // ---------------------------------------------------------------------------
  function automatic ttcw_item_t noise_item();
    ttcw_item_t it;
    it = ItemBits'({$urandom, $urandom});
    return it;
  endfunction

  function automatic ttcw_item_t put_item(logic [ByteW-1:0] ch, logic [ByteW-1:0] attr);
    ttcw_item_t it;
    it           = noise_item();
    it.opcode    = OP_PUT;
    it.char_code = ch;
    it.attribute = attr;
    return it;
  endfunction

  function automatic ttcw_item_t read_item(int unsigned row, int unsigned col);
    ttcw_item_t it;
    it          = noise_item();
    it.opcode   = OP_READ;
    it.read_row = RowFW'(row);
    it.read_col = ColFW'(col);
    return it;
  endfunction

  // Mostly cells on screen; the rest use the full field range, off-screen included.
  function automatic ttcw_item_t random_read();
    if ($urandom_range(0, 99) < 85) begin
      return read_item($urandom_range(0, Rows - 1), $urandom_range(0, Cols - 1));
    end
    return read_item($urandom_range(0, (1 << RowFW) - 1), $urandom_range(0, (1 << ColFW) - 1));
  endfunction

  function automatic logic [ByteW-1:0] text_char();
    logic [ByteW-1:0] ch;
    ch = ByteW'($urandom);
    if (ch == NewlineChar) ch = ch + 1'b1;
    return ch;
  endfunction

  function automatic ttcw_item_t text_item();
    return put_item(text_char(), ByteW'($urandom));
  endfunction

  // Newline while the slow budget lasts, plain text after.
  function automatic ttcw_item_t newline_item();
    if (slow_used < SlowCap) return put_item(NewlineChar, ByteW'($urandom));
    return text_item();
  endfunction

  function automatic ttcw_item_t clear_item();
    ttcw_item_t it;
    if (slow_used >= SlowCap) return random_read();
    it        = noise_item();
    it.opcode = OP_CLEAR;
    return it;
  endfunction

  function automatic ttcw_item_t unused_item();
    ttcw_item_t it;
    it        = noise_item();
    it.opcode = OpUnused;
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // Push side: idle gap, then hold the transaction until full drops.
  // Inputs change on the falling edge; full is sampled on the rising edge.
  // ---------------------------------------------------------------------------
  task automatic send_item(input ttcw_item_t it);
    int unsigned gap;
    gap = send_calm ? 0 : $urandom_range(0, MaxGap);
    repeat (gap) begin
      @(negedge clk_i);
      push   = 1'b0;
      item_i = noise_item();
    end
    @(negedge clk_i);
    push   = 1'b1;
    item_i = it;
    do @(posedge clk_i); while (full);
    n_items++;
    case (it.opcode)
      OP_PUT: begin
        if (it.char_code == NewlineChar) begin
          n_newline++;
          slow_used++;
        end else begin
          n_chars++;
        end
      end
      OP_READ:  n_reads++;
      OP_CLEAR: begin
        n_clears++;
        slow_used++;
      end
      default:  n_unused++;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Pop side: random stall before each transaction, with calm stretches.
  // ---------------------------------------------------------------------------
  initial begin : result_drain
    int unsigned stall;
    stall = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall != 0) begin
        pop = 1'b0;
        stall--;
      end else begin
        pop = 1'b1;
      end
      @(posedge clk_i);
      if (pop && !empty) begin
        if ($urandom_range(0, 39) == 0) pop_calm = !pop_calm;
        stall = pop_calm ? 0 : $urandom_range(0, MaxGap);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned kind;
    int unsigned len;
    int unsigned pick;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // Directed: reset contents at both corners, byte extremes, off-screen reads
    // on each axis, the unused opcode, a newline that does not scroll, and a
    // clear whose attribute must be ignored. Items queue up during the clearing
    // pass after reset.
    send_item(read_item(0, 0));
    send_item(read_item(Rows - 1, Cols - 1));
    send_item(put_item(8'h00, 8'h00));
    send_item(put_item(8'hFF, 8'hFF));
    send_item(read_item(0, 0));
    send_item(read_item(0, 1));
    send_item(read_item(Rows, 0));
    send_item(read_item(0, Cols));
    send_item(read_item((1 << RowFW) - 1, (1 << ColFW) - 1));
    send_item(unused_item());
    send_item(put_item(NewlineChar, 8'hA5));
    send_item(put_item(8'h41, 8'h1E));
    send_item(read_item(1, 0));
    send_item(clear_item());
    send_item(read_item(0, 0));
    send_item(read_item(1, 0));

    // Random part opens by walking down past the last row (scroll) and then
    // filling the whole bottom row plus one, which wraps to row 0 unscrolled.
    repeat (Rows + 1) send_item(newline_item());
    send_item(read_item(Rows - 1, $urandom_range(0, Cols - 1)));
    repeat (Cols + 1) send_item(text_item());
    send_item(read_item(Rows - 1, Cols - 1));

    while (n_items < ItemTarget) begin
      kind      = $urandom_range(0, 99);
      send_calm = ($urandom_range(0, 3) == 0);
      if (kind < 40) begin
        // mixed traffic
        len = $urandom_range(5, 30);
        repeat (len) begin
          pick = $urandom_range(0, 99);
          if (pick < 45)      send_item(text_item());
          else if (pick < 52) send_item(newline_item());
          else if (pick < 88) send_item(random_read());
          else if (pick < 96) send_item(unused_item());
          else                send_item(clear_item());
        end
      end else if (kind < 60) begin
        // long text runs so rows fill and the cursor wraps
        len = $urandom_range(20, 170);
        repeat (len) begin
          if ($urandom_range(0, 9) == 0) send_item(random_read());
          else                           send_item(text_item());
        end
      end else if (kind < 75) begin
        // newline runs, each followed by a look at the bottom row
        len = $urandom_range(1, 6);
        repeat (len) begin
          send_item(newline_item());
          send_item(read_item(Rows - 1, $urandom_range(0, Cols - 1)));
        end
      end else if (kind < 95) begin
        len = $urandom_range(5, 25);
        repeat (len) send_item(random_read());
      end else begin
        send_item(clear_item());
        repeat (3) send_item(random_read());
      end
    end

    @(negedge clk_i);
    push = 1'b0;

    // Every item yields one result: wait for the last, then a short quiet
    // window to catch anything extra coming out.
    while (outstanding != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Covered %0d transactions: %0d characters, %0d newlines, %0d reads, %0d clears,",
             n_items, n_chars, n_newline, n_reads, n_clears);
    $display("%0d unused opcodes; %0d scrolls seen, %0d mismatches.",
             n_unused, scroll_count, fail_count);
    if (fail_count == 0 && outstanding == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog: sized from the slowest legal run (capped slow items, full gaps
  // and stalls on every item, clearing pass after reset) with a wide margin.
  initial begin : watchdog
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
